[rtl/bic_pkg.sv]
// Shared types and constants for the BACnet/IP header classifier.
`default_nettype none
package bic_pkg;

  localparam int COUNTER_BITS = 32;
  localparam int NUM_COUNTERS = 57;
  localparam int IDX_W = 6;
  localparam int MIDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 2;

  // Counter map
  localparam logic [IDX_W-1:0] CNT_TOTAL   = 6'd0;
  localparam logic [IDX_W-1:0] CNT_BVLC    = 6'd1;
  localparam logic [IDX_W-1:0] CNT_NPDU    = 6'd25;
  localparam logic [IDX_W-1:0] CNT_NLM     = 6'd35;
  localparam logic [IDX_W-1:0] CNT_APDU    = 6'd47;
  localparam logic [IDX_W-1:0] CNT_UCBC    = 6'd55;
  localparam logic [IDX_W-1:0] CNT_BADTYPE = 6'd56;

  // Request selector codes
  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Summary status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NOT_BACN  = 3'd1;
  localparam logic [2:0] STAT_BVLC_BAD  = 3'd2;
  localparam logic [2:0] STAT_BAD_VER   = 3'd3;
  localparam logic [2:0] STAT_TRUNCATED = 3'd4;

  // Message classes
  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_NLM  = 2'd1;
  localparam logic [1:0] CLASS_APDU = 2'd2;

  // Protocol constants
  localparam logic [7:0] BVLC_TYPE    = 8'h81;
  localparam logic [7:0] NPDU_VERSION = 8'h01;
  localparam logic [7:0] NLM_RES_LO   = 8'h0a;
  localparam logic [7:0] NLM_RES_HI   = 8'h7f;
  localparam logic [15:0] BVLC_FIXED_LEN = 16'd6;

  // Parser stages
  typedef enum logic [5:0] {
    ST_BVLC = 6'b000001,
    ST_NPDU = 6'b000010,
    ST_DLEN = 6'b000100,
    ST_SLEN = 6'b001000,
    ST_TYPE = 6'b010000,
    ST_DONE = 6'b100000
  } stage_t;

  // Work passed from the parser to the counter side
  typedef enum logic [1:0] {
    OP_BUMP    = 2'd0,
    OP_SUMMARY = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [NUM_COUNTERS-1:0] bump;
    logic [2:0]              status;
    logic [1:0]              msg_class;
    logic [7:0]              type_code;
    logic [IDX_W-1:0]        index;
  } rec_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [1:0]  msg_class;
    logic [7:0]  type_code;
    logic [31:0] count;
  } res_t;

  // One-hot mask selecting a single counter; all zeros for an index past the last counter.
  function automatic logic [NUM_COUNTERS-1:0] cnt_bit(input logic [IDX_W-1:0] idx);
    logic [NUM_COUNTERS-1:0] m;
    m = '0;
    if (32'(idx) < NUM_COUNTERS) begin
      m[idx] = 1'b1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[rtl/bic_front.sv]
// Byte parser: tracks BVLC/NPDU header state and turns each request into counter work.
`default_nettype none
module bic_front
  import bic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_byte,
  input  wire logic        last_byte,
  input  wire logic [31:0] dest_ip,
  input  wire logic [5:0]  counter_index,
  output rec_t             rec,
  output logic             rec_valid
);

  logic [15:0] pos, pos_next;
  stage_t      stage, stage_next;
  logic [15:0] blen, blen_next;
  logic [7:0]  bfunc, bfunc_next;
  logic [7:0]  ctrl, ctrl_next;
  logic [16:0] endo, endo_next;
  logic [2:0]  pstat, pstat_next;
  logic        bcast, bcast_next;
  logic [1:0]  mcls, mcls_next;
  logic [7:0]  mtype, mtype_next;

  // Parse one byte against the current header state.
  always_comb begin
    logic [15:0] start;
    logic [16:0] fin;
    logic        do_fin;
    logic        valid;
    logic [15:0] lenw;
    logic [3:0]  nib;
    rec_t        r;

    // Packet state as seen by this byte (fresh on a first byte).
    pos_next   = first_byte ? 16'd0 : pos;
    stage_next = first_byte ? ST_BVLC : stage;
    blen_next  = first_byte ? 16'd0 : blen;
    bfunc_next = first_byte ? 8'd0 : bfunc;
    ctrl_next  = first_byte ? 8'd0 : ctrl;
    endo_next  = first_byte ? 17'd0 : endo;
    pstat_next = first_byte ? STAT_OK : pstat;
    mcls_next  = first_byte ? CLASS_NONE : mcls;
    mtype_next = first_byte ? 8'd0 : mtype;
    bcast_next = first_byte ? (dest_ip[7:0] == 8'hff) : bcast;

    r           = '0;
    r.op        = OP_BUMP;
    r.index     = counter_index;
    fin         = '0;
    do_fin      = 1'b0;
    valid       = 1'b0;
    lenw        = {blen_next[15:8], data_byte};
    nib         = data_byte[7:4];

    if (bfunc_next == 8'd0) begin
      start = 16'd6;
    end else if (bfunc_next == 8'd4) begin
      start = 16'd10;
    end else begin
      start = 16'd4;
    end

    case (stage_next)
      ST_BVLC: begin
        if (pos_next == 16'd0) begin
          if (data_byte != BVLC_TYPE) begin
            pstat_next = STAT_NOT_BACN;
            stage_next = ST_DONE;
          end else begin
            r.bump = r.bump | cnt_bit(CNT_TOTAL);
          end
        end else if (pos_next == 16'd1) begin
          bfunc_next = data_byte;
        end else if (pos_next == 16'd2) begin
          blen_next = {data_byte, 8'd0};
        end else if (pos_next == 16'd3) begin
          blen_next = lenw;
          if (bfunc_next == 8'd0 || bfunc_next == 8'd5) begin
            valid = (lenw == BVLC_FIXED_LEN);
          end else begin
            valid = (bfunc_next == 8'd4) || (bfunc_next >= 8'd6 && bfunc_next <= 8'd11);
          end
          if (bfunc_next <= 8'd11) begin
            r.bump = r.bump | cnt_bit(CNT_BVLC + {bfunc_next[4:0], 1'b0} + {5'd0, !valid});
          end
          if (!valid) begin
            pstat_next = STAT_BVLC_BAD;
            stage_next = ST_DONE;
          end else if (lenw == start) begin
            stage_next = ST_DONE;
          end else begin
            stage_next = ST_NPDU;
          end
        end
      end
      ST_NPDU: begin
        if (pos_next == start) begin
          if (data_byte != NPDU_VERSION) begin
            r.bump     = r.bump | cnt_bit(CNT_NPDU);
            pstat_next = STAT_BAD_VER;
            stage_next = ST_DONE;
          end
        end else if (pos_next == start + 16'd1) begin
          ctrl_next = data_byte;
          if (data_byte[7]) begin
            mcls_next = CLASS_NLM;
            r.bump    = r.bump | cnt_bit(CNT_NPDU + 6'd1);
          end else begin
            mcls_next = CLASS_APDU;
            r.bump    = r.bump | cnt_bit(CNT_NPDU + 6'd2);
          end
          if (data_byte[5]) r.bump = r.bump | cnt_bit(CNT_NPDU + 6'd3);
          if (data_byte[3]) r.bump = r.bump | cnt_bit(CNT_NPDU + 6'd4);
          if (data_byte[6]) r.bump = r.bump | cnt_bit(CNT_NPDU + 6'd5);
          r.bump = r.bump | cnt_bit(CNT_NPDU + 6'd9 - {4'd0, data_byte[1:0]});
          if (data_byte[5]) begin
            endo_next  = {1'b0, start + 16'd4};
            stage_next = ST_DLEN;
          end else if (data_byte[3]) begin
            endo_next  = {1'b0, start + 16'd4};
            stage_next = ST_SLEN;
          end else begin
            fin    = {1'b0, start + 16'd2};
            do_fin = 1'b1;
          end
        end
      end
      ST_DLEN: begin
        if ({1'b0, pos_next} == endo_next) begin
          if (ctrl_next[3]) begin
            endo_next  = {1'b0, pos_next} + 17'd3 + {9'd0, data_byte};
            stage_next = ST_SLEN;
          end else begin
            fin    = {1'b0, pos_next} + 17'd2 + {9'd0, data_byte};
            do_fin = 1'b1;
          end
        end
      end
      ST_SLEN: begin
        if ({1'b0, pos_next} == endo_next) begin
          fin    = {1'b0, pos_next} + 17'd1 + {9'd0, data_byte} + {16'd0, ctrl_next[5]};
          do_fin = 1'b1;
        end
      end
      ST_TYPE: begin
        if ({1'b0, pos_next} == endo_next) begin
          if (ctrl_next[7]) begin
            mtype_next = data_byte;
            if (data_byte <= 8'd9) begin
              r.bump = r.bump | cnt_bit(CNT_NLM + data_byte[5:0]);
            end else if (data_byte >= NLM_RES_LO && data_byte <= NLM_RES_HI) begin
              r.bump = r.bump | cnt_bit(CNT_NLM + 6'd10);
            end else begin
              r.bump = r.bump | cnt_bit(CNT_NLM + 6'd11);
            end
          end else begin
            mtype_next = {4'd0, nib};
            if (nib == 4'd1 && bcast_next) r.bump = r.bump | cnt_bit(CNT_UCBC);
            if (nib <= 4'd7) begin
              r.bump = r.bump | cnt_bit(CNT_APDU + {2'd0, nib});
            end else begin
              r.bump = r.bump | cnt_bit(CNT_BADTYPE);
            end
          end
          stage_next = ST_DONE;
        end
      end
      default: begin
      end
    endcase

    // End of the NPCI: the type byte follows unless the BVLC length ends here.
    if (do_fin) begin
      endo_next  = {1'b0, fin[15:0]};
      stage_next = (blen_next == fin[15:0]) ? ST_DONE : ST_TYPE;
    end

    if (pos_next != 16'hffff) begin
      pos_next = pos_next + 16'd1;
    end

    // Summary at the end of a packet, then a fresh packet state.
    r.status    = (pstat_next == STAT_OK && stage_next != ST_DONE) ? STAT_TRUNCATED : pstat_next;
    r.msg_class = mcls_next;
    r.type_code = mtype_next;
    if (last_byte) begin
      r.op       = OP_SUMMARY;
      pos_next   = 16'd0;
      stage_next = ST_BVLC;
      blen_next  = 16'd0;
      bfunc_next = 8'd0;
      ctrl_next  = 8'd0;
      endo_next  = 17'd0;
      pstat_next = STAT_OK;
      mcls_next  = CLASS_NONE;
      mtype_next = 8'd0;
    end

    // Counter reads and clears bypass the parser.
    if (func == FUNC_READ) begin
      r      = '0;
      r.op   = OP_READ;
      r.index = counter_index;
    end else if (func == FUNC_CLEAR) begin
      r      = '0;
      r.op   = OP_CLEAR;
    end
    rec = r;
  end

  assign rec_valid = take && (func == FUNC_BYTE || func == FUNC_READ || func == FUNC_CLEAR);

  // Header state advances only on accepted payload bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      stage <= ST_BVLC;
      blen  <= '0;
      bfunc <= '0;
      ctrl  <= '0;
      endo  <= '0;
      pstat <= STAT_OK;
      bcast <= 1'b0;
      mcls  <= CLASS_NONE;
      mtype <= '0;
    end else if (take && func == FUNC_BYTE) begin
      pos   <= pos_next;
      stage <= stage_next;
      blen  <= blen_next;
      bfunc <= bfunc_next;
      ctrl  <= ctrl_next;
      endo  <= endo_next;
      pstat <= pstat_next;
      bcast <= bcast_next;
      mcls  <= mcls_next;
      mtype <= mtype_next;
    end
  end

endmodule
`default_nettype wire

[rtl/bic_queue.sv]
// Short queue of counter work between the parser and the counter bank.
`default_nettype none
module bic_queue
  import bic_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  rec_t      wdata,
  output logic      full,
  input  wire logic pop,
  output rec_t      rdata,
  output logic      avail
);

  localparam int PW = $clog2(MIDQ_DEPTH);

  rec_t          slots [MIDQ_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (PW+1)'(MIDQ_DEPTH));
  assign avail   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && avail;
  assign rdata   = slots[rptr];

  // Storage is written only at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

[rtl/bic_back.sv]
// Statistics counter bank and result queue.
`default_nettype none
module bic_back
  import bic_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  rec_t      rec,
  input  wire logic rec_avail,
  output logic      rec_pop,
  input  wire logic pop,
  output logic      empty,
  output res_t      res
);

  logic [COUNTER_BITS-1:0] cnt [NUM_COUNTERS];
  res_t                    oq [OUTQ_DEPTH];
  logic                    ohead;
  logic                    otail;
  logic [1:0]              ocount;
  logic                    ofull;
  logic                    opush;
  logic                    opop;
  res_t                    nres;
  logic                    is_clear;

  assign ofull    = (ocount == 2'(OUTQ_DEPTH));
  assign empty    = (ocount == 2'd0);
  assign rec_pop  = rec_avail && !ofull;
  assign opop     = pop && !empty;
  assign opush    = rec_pop && (rec.op == OP_SUMMARY || rec.op == OP_READ);
  assign is_clear = rec_pop && (rec.op == OP_CLEAR);
  assign res      = oq[ohead];

  // Build the result: a summary or the selected counter value.
  always_comb begin
    nres           = '0;
    nres.kind      = (rec.op == OP_READ);
    nres.status    = rec.status;
    nres.msg_class = rec.msg_class;
    nres.type_code = rec.type_code;
    if (rec.op == OP_READ && 32'(rec.index) < NUM_COUNTERS) begin
      nres.count = 32'(cnt[rec.index]);
    end
  end

  // Each counter wraps on its own bump and zeroes on a clear.
  for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_cnt
    always_ff @(posedge clk) begin
      if (rst || is_clear) begin
        cnt[i] <= '0;
      end else if (rec_pop && rec.bump[i]) begin
        cnt[i] <= cnt[i] + 1'b1;
      end
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (opush) begin
      oq[otail] <= nres;
    end
  end

  // Result queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ohead  <= 1'b0;
      otail  <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (opush) otail <= otail + 1'b1;
      if (opop)  ohead <= ohead + 1'b1;
      ocount <= ocount + 2'(opush) - 2'(opop);
    end
  end

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    is_clear |=> (cnt[0] == '0 && cnt[NUM_COUNTERS-1] == '0))
    else $error("counters not cleared");
  a_ocount_range: assert property (@(posedge clk) disable iff (rst)
    ocount <= 2'(OUTQ_DEPTH))
    else $error("result queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ofull |-> !opush)
    else $error("result pushed into full queue");
  a_total_bump: assert property (@(posedge clk) disable iff (rst)
    (rec_pop && rec.bump[0] && rec.op != OP_CLEAR) |=> cnt[0] == $past(cnt[0]) + 1'b1)
    else $error("packet total counter missed a bump");

endmodule
`default_nettype wire

[rtl/bacnet_ip_header_classifier_core.sv]
// Top level of the BACnet/IP header classifier.
`default_nettype none
// Takes one request per cycle while full is low: payload bytes, counter reads and
// counter clears. A parser checks each byte against the BVLC and NPDU header state
// and turns it into counter work, which waits in a four-entry queue; the counter
// bank takes one entry per cycle while the result queue has room, so the sustained
// rate is one request per clock while results are popped. A summary or counter
// read passes the work queue, then a two-entry result queue. Reads and clears see
// every counter update of earlier requests. There is no clearing pass after reset.
module bacnet_ip_header_classifier_core
  import bic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_byte,
  input  wire logic        last_byte,
  input  wire logic [31:0] dest_ip,
  input  wire logic [5:0]  counter_index,
  output logic             empty,
  input  wire logic        pop,
  output logic             result_kind,
  output logic [2:0]       status,
  output logic [1:0]       message_class,
  output logic [7:0]       type_code,
  output logic [31:0]      count_value
);

  rec_t rec_in;
  logic rec_in_valid;
  rec_t rec_out;
  logic rec_avail;
  logic rec_pop;
  res_t res;
  logic take;

  assign take = push && !full;

  // Header parser.
  bic_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .func          (func),
    .data_byte     (data_byte),
    .first_byte    (first_byte),
    .last_byte     (last_byte),
    .dest_ip       (dest_ip),
    .counter_index (counter_index),
    .rec           (rec_in),
    .rec_valid     (rec_in_valid)
  );

  // Decoupling queue.
  bic_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_in_valid),
    .wdata (rec_in),
    .full  (full),
    .pop   (rec_pop),
    .rdata (rec_out),
    .avail (rec_avail)
  );

  // Counter bank and results.
  bic_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec       (rec_out),
    .rec_avail (rec_avail),
    .rec_pop   (rec_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign result_kind   = res.kind;
  assign status        = res.status;
  assign message_class = res.msg_class;
  assign type_code     = res.type_code;
  assign count_value   = res.count;

endmodule
`default_nettype wire
